// ===== rtl/core/u8u16_pkg.sv =====
// Shared types and constants of the UTF-8 to UTF-16 decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
`timescale 1ns / 1ps

package u8u16_pkg;

  // Most code units that one input byte can cause.
  localparam int unsigned UnitsMax = 4;
  localparam int unsigned UnitCntW = $clog2(UnitsMax + 1);
  localparam int unsigned UnitIdxW = $clog2(UnitsMax);

  // Entries of the job queue between front and back.
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  // Code units and UTF-16 offsets.
  localparam logic [15:0] ReplChar   = 16'hfffd;
  localparam logic [15:0] HiSurrBase = 16'hd800;
  localparam logic [15:0] LoSurrBase = 16'hdc00;
  localparam logic [20:0] SuppBase   = 21'h10000;

  // Lead and continuation byte codes.
  localparam logic [7:0] LeadC0   = 8'hc0;
  localparam logic [7:0] LeadC2   = 8'hc2;
  localparam logic [7:0] LeadE0   = 8'he0;
  localparam logic [7:0] LeadF0   = 8'hf0;
  localparam logic [7:0] LeadF4   = 8'hf4;
  localparam logic [7:0] ContMin  = 8'h80;
  localparam logic [7:0] E0SecMin = 8'ha0;
  localparam logic [7:0] F0SecMin = 8'h90;
  localparam logic [7:0] F4SecMax = 8'h8f;

  // One UTF-16 code unit with its replacement flag.
  typedef struct packed {
    logic [15:0] code;
    logic        replaced;
  } unit_t;

  // All code units caused by one input byte, in output order.
  typedef struct packed {
    unit_t [UnitsMax-1:0] units;
    logic  [UnitCntW-1:0] cnt;
    logic                 str_end;
  } job_t;

endpackage

// ===== rtl/core/u8u16_front.sv =====
// Front end: accepts UTF-8 bytes, tracks the pending sequence and builds one job per byte.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       byte_i,
  input  logic             str_end_i,
  input  logic             accept_i,
  output u8u16_pkg::job_t  job_o,
  output logic             push_o
);

  logic [1:0] pend_cnt_q, pend_cnt_d;
  logic [7:0] pend_q [3];
  logic [7:0] pend_d [3];

  // Appends one code unit to a job unless it is already full.
  function automatic u8u16_pkg::job_t push_unit(u8u16_pkg::job_t j, logic [15:0] c,
                                                logic r);
    if (j.cnt < u8u16_pkg::UnitCntW'(u8u16_pkg::UnitsMax)) begin
      j.units[j.cnt[u8u16_pkg::UnitIdxW-1:0]].code     = c;
      j.units[j.cnt[u8u16_pkg::UnitIdxW-1:0]].replaced = r;
      j.cnt = j.cnt + u8u16_pkg::UnitCntW'(1);
    end
    return j;
  endfunction

  logic [7:0]  lead;
  logic        cont_ok;
  logic [2:0]  seq_len;
  logic [20:0] cp;
  logic [19:0] supp;
  logic        do_start;

  // Classification of the incoming byte against the pending lead.
  always_comb begin
    lead = pend_q[0];
    if (byte_i[7:6] != 2'b10) begin
      cont_ok = 1'b0;
    end else if (lead == u8u16_pkg::LeadC0) begin
      cont_ok = (byte_i == u8u16_pkg::ContMin);
    end else if (pend_cnt_q == 2'd1) begin
      cont_ok = !((lead == u8u16_pkg::LeadE0 && byte_i < u8u16_pkg::E0SecMin) ||
                  (lead == u8u16_pkg::LeadF0 && byte_i < u8u16_pkg::F0SecMin) ||
                  (lead == u8u16_pkg::LeadF4 && byte_i > u8u16_pkg::F4SecMax));
    end else begin
      cont_ok = 1'b1;
    end
    if (lead >= u8u16_pkg::LeadF0) begin
      seq_len = 3'd4;
    end else if (lead >= u8u16_pkg::LeadE0) begin
      seq_len = 3'd3;
    end else begin
      seq_len = 3'd2;
    end
    unique case (seq_len)
      3'd2:    cp = {10'd0, lead[4:0], byte_i[5:0]};
      3'd3:    cp = {5'd0, lead[3:0], pend_q[1][5:0], byte_i[5:0]};
      default: cp = {lead[2:0], pend_q[1][5:0], pend_q[2][5:0], byte_i[5:0]};
    endcase
    supp = 20'(cp - u8u16_pkg::SuppBase);
  end

  // Job assembly, following the byte's effect on the pending sequence.
  always_comb begin
    job_o         = '0;
    job_o.str_end = str_end_i;
    pend_cnt_d    = pend_cnt_q;
    pend_d        = pend_q;
    do_start      = 1'b0;
    if (pend_cnt_q == 2'd0) begin
      do_start = 1'b1;
    end else if (!cont_ok) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < pend_cnt_q) begin
          job_o = push_unit(job_o, u8u16_pkg::ReplChar, 1'b1);
        end
      end
      pend_cnt_d = 2'd0;
      do_start   = 1'b1;
    end else if (3'(pend_cnt_q) + 3'd1 < seq_len) begin
      pend_d[pend_cnt_q] = byte_i;
      pend_cnt_d         = pend_cnt_q + 2'd1;
    end else begin
      pend_cnt_d = 2'd0;
      if (cp[20:16] == 5'd0) begin
        job_o = push_unit(job_o, cp[15:0], 1'b0);
      end else begin
        job_o = push_unit(job_o, u8u16_pkg::HiSurrBase + {6'd0, supp[19:10]}, 1'b0);
        job_o = push_unit(job_o, u8u16_pkg::LoSurrBase + {6'd0, supp[9:0]}, 1'b0);
      end
    end
    // A new lead byte: ASCII passes, valid leads are buffered, the rest is replaced.
    if (do_start) begin
      if (!byte_i[7]) begin
        job_o = push_unit(job_o, {8'd0, byte_i}, 1'b0);
      end else if (byte_i == u8u16_pkg::LeadC0 ||
                   (byte_i >= u8u16_pkg::LeadC2 && byte_i <= u8u16_pkg::LeadF4)) begin
        pend_d[0]  = byte_i;
        pend_cnt_d = 2'd1;
      end else begin
        job_o = push_unit(job_o, u8u16_pkg::ReplChar, 1'b1);
      end
    end
    // End of string flushes whatever is still buffered.
    if (str_end_i) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < pend_cnt_d) begin
          job_o = push_unit(job_o, u8u16_pkg::ReplChar, 1'b1);
        end
      end
      pend_cnt_d = 2'd0;
    end
  end

  assign push_o = accept_i && (job_o.cnt != '0);

  // Pending count is control state; the buffered bytes need no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cnt_q <= 2'd0;
    end else if (accept_i) begin
      pend_cnt_q <= pend_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pend_q <= pend_d;
    end
  end

endmodule

// ===== rtl/core/u8u16_queue.sv =====
// Short job queue between the front and back ends.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  u8u16_pkg::job_t  job_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output u8u16_pkg::job_t  job_o
);

  u8u16_pkg::job_t mem_q [u8u16_pkg::QDepth];
  logic [u8u16_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [u8u16_pkg::QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == u8u16_pkg::QCntW'(u8u16_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + u8u16_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + u8u16_pkg::QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + u8u16_pkg::QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - u8u16_pkg::QCntW'(1);
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== rtl/core/u8u16_back.sv =====
// Back end: walks the code units of the head job onto the output stream.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  u8u16_pkg::job_t  job_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [15:0]      code_o,
  output logic             replaced_o,
  output logic             last_o
);

  logic [u8u16_pkg::UnitIdxW-1:0] idx_q;
  logic                           final_unit;
  logic                           take;

  assign final_unit  = ({1'b0, idx_q} == job_i.cnt - u8u16_pkg::UnitCntW'(1));
  assign take        = valid_i && out_ready_i;
  assign out_valid_o = valid_i;
  assign code_o      = job_i.units[idx_q].code;
  assign replaced_o  = job_i.units[idx_q].replaced;
  assign last_o      = job_i.str_end && final_unit;
  assign pop_o       = take && final_unit;

  // Unit index within the head job.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (take) begin
      if (final_unit) begin
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + u8u16_pkg::UnitIdxW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/utf8_to_utf16_decoder_top.sv =====
// Top level of the UTF-8 to UTF-16 decoder: front end, job queue and back end.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue and u8u16_back.
`timescale 1ns / 1ps

// Usage:
// The slave stream carries one UTF-8 byte per request in s_axis_tdata_i, with
// s_axis_tlast_i high on the last byte of a string. The master stream carries
// one UTF-16 code unit per request in m_axis_tdata_o; m_axis_tuser_o is high on
// a U+FFFD that replaces malformed input, and m_axis_tlast_o marks the final
// code unit caused by a string's last byte.
// An accepted byte's code units are written into the job queue and sent after those of earlier bytes.
// A byte causes zero to four code units; the back end sends one unit per cycle
// while the receiver is ready, so the sustained rate is one byte per cycle while
// each byte yields at most one unit and the receiver stays ready.
// Bytes that only extend a pending sequence produce no output.
// A two-entry job queue parts the sides: input is taken while a result waits,
// and s_axis_tready_o drops only when both entries are full, which happens when
// the receiver stalls or when bytes yielding several units arrive faster than
// the back end drains them. Reset clears the pending sequence and empties the queue.
module utf8_to_utf16_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] code_unit
  output logic        m_axis_tuser_o,   // [0] replaced
  output logic        m_axis_tlast_o
);

  u8u16_pkg::job_t front_job, head_job;
  logic            push, q_full, q_valid, pop, accept;

  assign s_axis_tready_o = !q_full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Byte classification and pending-sequence tracking.
  u8u16_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (s_axis_tdata_i),
    .str_end_i (s_axis_tlast_i),
    .accept_i  (accept),
    .job_o     (front_job),
    .push_o    (push)
  );

  // Jobs waiting for the output side.
  u8u16_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  // Code unit serializer.
  u8u16_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .code_o      (m_axis_tdata_o),
    .replaced_o  (m_axis_tuser_o),
    .last_o      (m_axis_tlast_o)
  );

`ifndef NO_ASSERTIONS
  // The front never pushes a job into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("job pushed into a full queue");

  // Every queued job carries at least one code unit.
  a_job_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid |-> head_job.cnt != '0)
    else $error("empty job at queue head");

  // A replacement flag always comes with the replacement character.
  a_repl_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == u8u16_pkg::ReplChar)
    else $error("replaced flag on a code unit other than U+FFFD");
`endif

endmodule

// ===== tb/sv/utf16_unit_checker.sv =====
// Checker for the UTF-8 to UTF-16 decoder: watches both streams, predicts the
// code units of every accepted byte and compares them in order.
// Depends on u8u16_pkg for the unit type and the byte and code unit constants.
`timescale 1ns / 1ps

module utf16_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,   // [7:0] data_byte
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,   // [15:0] code_unit
  input  logic        m_tuser_i,   // [0] replaced
  input  logic        m_tlast_i,
  output int          mismatches_o,
  output int          units_due_o
);

  import u8u16_pkg::*;

  // One expected code unit together with its end-of-string mark.
  typedef struct packed {
    unit_t unit;
    logic  last;
  } expected_unit_t;

  expected_unit_t due_q[$];     // code units still to arrive, oldest first
  unit_t          step_units[$]; // code units caused by the byte in work
  logic [7:0]     held [3];      // bytes of the unfinished sequence
  logic [1:0]     held_cnt;

  // Total length of the sequence that a lead byte opens.
  function automatic int unsigned seq_len(input logic [7:0] lead);
    if (lead >= LeadF0) return 4;
    if (lead >= LeadE0) return 3;
    return 2;
  endfunction

  // Whether a byte may follow at position pos of the sequence opened by lead.
  function automatic logic cont_ok(input logic [7:0] lead, input int unsigned pos,
                                   input logic [7:0] b);
    if (b[7:6] != 2'b10) return 1'b0;
    if (lead == LeadC0) return b == ContMin;
    if (pos == 1) begin
      if (lead == LeadE0 && b < E0SecMin) return 1'b0;
      if (lead == LeadF0 && b < F0SecMin) return 1'b0;
      if (lead == LeadF4 && b > F4SecMax) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic emit(input logic [15:0] code, input logic repl);
    unit_t u;
    u.code     = code;
    u.replaced = repl;
    step_units = {step_units, u};
  endtask

  // Each buffered byte of a malformed sequence turns into one replacement.
  task automatic flush_held();
    for (int i = 0; i < held_cnt; i++) emit(ReplChar, 1'b1);
    held_cnt = '0;
  endtask

  task automatic open_sequence(input logic [7:0] b);
    if (b < ContMin) begin
      emit({8'h00, b}, 1'b0);
    end else if (b == LeadC0 || (b >= LeadC2 && b <= LeadF4)) begin
      held[0]  = b;
      held_cnt = 2'd1;
    end else begin
      emit(ReplChar, 1'b1);
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    logic [7:0]  lead;
    int unsigned pos;
    logic [20:0] cp;
    logic [20:0] off;
    if (held_cnt == 0) begin
      open_sequence(b);
      return;
    end
    lead = held[0];
    pos  = held_cnt;
    // A byte that breaks the sequence is decoded again as a new lead.
    if (!cont_ok(lead, pos, b)) begin
      flush_held();
      open_sequence(b);
      return;
    end
    if (pos + 1 < seq_len(lead)) begin
      held[pos] = b;
      held_cnt  = 2'(pos + 1);
      return;
    end
    case (seq_len(lead))
      2: cp = {10'd0, lead[4:0], b[5:0]};
      3: cp = {5'd0, lead[3:0], held[1][5:0], b[5:0]};
      default: cp = {lead[2:0], held[1][5:0], held[2][5:0], b[5:0]};
    endcase
    held_cnt = '0;
    // Code points above the basic plane leave as a surrogate pair.
    if (cp < SuppBase) begin
      emit(cp[15:0], 1'b0);
    end else begin
      off = cp - SuppBase;
      emit(HiSurrBase + {6'd0, off[19:10]}, 1'b0);
      emit(LoSurrBase + {6'd0, off[9:0]}, 1'b0);
    end
  endtask

  // Queue the code units of one accepted byte; the last one of a string's
  // final byte carries the end mark.
  task automatic predict_units(input logic [7:0] b, input logic last);
    expected_unit_t e;
    step_units.delete();
    take_byte(b);
    if (last) flush_held();
    foreach (step_units[i]) begin
      e.unit = step_units[i];
      e.last = last && (i == step_units.size() - 1);
      due_q  = {due_q, e};
    end
  endtask

  task automatic field_mismatch(input string field, input logic [15:0] expv,
                                input logic [15:0] actv);
    $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, expv, actv);
    mismatches_o++;
  endtask

  // Outputs are compared before the new byte is predicted: a code unit never
  // leaves at the same edge as the byte that causes it.
  always @(posedge clk_i or negedge rst_ni) begin : check_units
    expected_unit_t want;
    if (!rst_ni) begin
      held_cnt = '0;
      due_q.delete();
      units_due_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (due_q.size() == 0) begin
          $display("%0t ns: unexpected code unit, expected none, actual %h user %b last %b",
                   $time, m_tdata_i, m_tuser_i, m_tlast_i);
          mismatches_o++;
        end else begin
          want = due_q.pop_front();
          if (m_tdata_i !== want.unit.code)
            field_mismatch("code_unit", want.unit.code, m_tdata_i);
          if (m_tuser_i !== want.unit.replaced)
            field_mismatch("replaced", {15'd0, want.unit.replaced}, {15'd0, m_tuser_i});
          if (m_tlast_i !== want.last)
            field_mismatch("last_unit", {15'd0, want.last}, {15'd0, m_tlast_i});
        end
      end
      if (s_tvalid_i && s_tready_i) predict_units(s_tdata_i, s_tlast_i);
      units_due_o <= due_q.size();
    end
  end

endmodule

// ===== tb/sv/utf8_to_utf16_decoder_top_tb.sv =====
// Testbench top of the UTF-8 to UTF-16 decoder: clock, reset, byte stimulus,
// receiver stalls, watchdog and verdict.
// Depends on u8u16_pkg, utf8_to_utf16_decoder_top and utf16_unit_checker.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_top_tb;

  import u8u16_pkg::*;

  // Byte values that bound the lead and continuation ranges.
  localparam logic [7:0] LeadDF  = 8'hdf;
  localparam logic [7:0] LeadEF  = 8'hef;
  localparam logic [7:0] ContMax = 8'hbf;

  localparam int RandItems   = 320;
  // The longest receiver hold-off and the sender gaps stay well below this limit;
  // a correct run never goes this long without a request on either side.
  localparam int IdleLimit   = 1000;
  localparam int DrainCycles = 16;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = 8'h00;  // [7:0] data_byte
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;           // [15:0] code_unit
  logic        m_axis_tuser_o;           // [0] replaced
  logic        m_axis_tlast_o;

  int mismatches;
  int units_due;
  int burst_left = 0;

  utf8_to_utf16_decoder_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  utf16_unit_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_i   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .s_tlast_i    (s_axis_tlast_i),
    .m_tvalid_i   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_i    (m_axis_tdata_o),
    .m_tuser_i    (m_axis_tuser_o),
    .m_tlast_i    (m_axis_tlast_o),
    .mismatches_o (mismatches),
    .units_due_o  (units_due)
  );

  // 20 ns clock.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Offer one byte at a falling edge and hold it until it is accepted. Bursts
  // of random length are parted by random gaps.
  task automatic send_byte_request(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    burst_left--;
    @(negedge clk_i);
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    logic [7:0] chr [4];
    int         len;
    int         n_chars;
    int         kind;
    int         flaw;
    int         random_bytes;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Smallest and largest single bytes.
    send_byte_request(8'h00, 1'b0);
    send_byte_request(8'h7f, 1'b1);
    // Two-byte null of modified UTF-8.
    send_byte_request(LeadC0, 1'b0);
    send_byte_request(ContMin, 1'b1);
    // Top of the two-byte range.
    send_byte_request(LeadDF, 1'b0);
    send_byte_request(ContMax, 1'b0);
    // Bottom of the three-byte range.
    send_byte_request(LeadE0, 1'b0);
    send_byte_request(E0SecMin, 1'b0);
    send_byte_request(ContMin, 1'b0);
    // Encoded high surrogate is passed through.
    send_byte_request(8'hed, 1'b0);
    send_byte_request(8'ha0, 1'b0);
    send_byte_request(ContMin, 1'b0);
    // Highest code point, a surrogate pair, ending the string.
    send_byte_request(LeadF4, 1'b0);
    send_byte_request(F4SecMax, 1'b0);
    send_byte_request(ContMax, 1'b0);
    send_byte_request(ContMax, 1'b1);
    // Invalid lead bytes.
    send_byte_request(8'h80, 1'b0);
    send_byte_request(8'hc1, 1'b0);
    send_byte_request(8'hff, 1'b0);
    // Second byte below the limit after E0 and F0, above it after F4.
    send_byte_request(LeadE0, 1'b0);
    send_byte_request(8'h9f, 1'b0);
    send_byte_request(LeadF0, 1'b0);
    send_byte_request(8'h8f, 1'b0);
    send_byte_request(LeadF4, 1'b0);
    send_byte_request(F0SecMin, 1'b0);
    // Three buffered bytes broken by a new lead, which the string end truncates.
    send_byte_request(8'hf1, 1'b0);
    send_byte_request(ContMin, 1'b0);
    send_byte_request(ContMin, 1'b0);
    send_byte_request(LeadC2, 1'b1);

    // Random strings: mostly well-formed characters, some noise, truncated
    // and broken sequences.
    random_bytes = 0;
    while (random_bytes < RandItems) begin
      n_chars = $urandom_range(1, 6);
      for (int c = 0; c < n_chars; c++) begin
        for (int i = 1; i < 4; i++) chr[i] = 8'($urandom_range(ContMin, ContMax));
        kind = $urandom_range(0, 3);
        case (kind)
          0: begin
            chr[0] = 8'($urandom_range(0, 8'h7f));
            len    = 1;
          end
          1: begin
            if ($urandom_range(0, 7) == 0) begin
              chr[0] = LeadC0;
              chr[1] = ContMin;
            end else begin
              chr[0] = 8'($urandom_range(LeadC2, LeadDF));
            end
            len = 2;
          end
          2: begin
            chr[0] = 8'($urandom_range(LeadE0, LeadEF));
            chr[1] = 8'($urandom_range(chr[0] == LeadE0 ? E0SecMin : ContMin, ContMax));
            len    = 3;
          end
          default: begin
            chr[0] = 8'($urandom_range(LeadF0, LeadF4));
            chr[1] = 8'($urandom_range(chr[0] == LeadF0 ? F0SecMin : ContMin,
                                       chr[0] == LeadF4 ? F4SecMax : ContMax));
            len    = 4;
          end
        endcase
        flaw = $urandom_range(0, 9);
        if (flaw == 0) begin
          chr[0] = 8'($urandom_range(0, 255));
          len    = 1;
        end else if (flaw == 1 && len > 1) begin
          len = $urandom_range(1, len - 1);
        end else if (flaw == 2 && len > 1) begin
          chr[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
        end
        for (int i = 0; i < len; i++) begin
          send_byte_request(chr[i], (c == n_chars - 1) && (i == len - 1));
          random_bytes++;
        end
      end
    end
    s_axis_tvalid_i <= 1'b0;

    // Wait for every expected code unit, then watch for stray ones.
    while (units_due != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Receiver: stretches of steady acceptance, light and heavy stalls, and now
  // and then a long hold-off that fills the queue and stalls the input.
  initial begin : receiver
    int seg;
    int mode;
    int span;
    seg = 0;
    @(posedge rst_ni);
    forever begin
      seg++;
      if (seg % 6 == 3) begin
        @(negedge clk_i);
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(100, 150)) @(negedge clk_i);
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(10, 60);
        repeat (span) begin
          @(negedge clk_i);
          case (mode)
            0: m_axis_tready_i <= 1'b1;
            1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  // Watchdog: ends the run when no request moves on either side for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t ns: no request accepted for %0d cycles", $time, IdleLimit);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
